// ----- src/vfm_pkg.sv -----
// shared types and constants for the volts-per-hertz pwm modulator
package vfm_pkg;

  // default number of entries in the sine table
  localparam int SINE_ROM_DEPTH_DEF = 1024;

  // phase offsets in units of 2^-32 turn
  localparam logic [31:0] THIRD_TURN   = 32'h5555_5555;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // pi/2 in q2.30, used when the sine table is built
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // dividend bits handled by the serial divider
  localparam int DIV_STEPS = 41;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DRIVE_MODE   = 3'd0,
    REG_FREQ_TARGET  = 3'd1,
    REG_FREQ_STEP    = 3'd2,
    REG_PHASE_GAIN   = 3'd3,
    REG_VOLTS_PER_HZ = 3'd4,
    REG_VDC_MINIMUM  = 3'd5,
    REG_TEST_DUTY    = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RAMP,
    S_GAIN,
    S_PHASE,
    S_ADDR,
    S_READ,
    S_INTERP,
    S_COS,
    S_SCALE,
    S_PREP,
    S_DIV,
    S_STORE,
    S_MID,
    S_DUTY
  } state_t;

endpackage

// ----- src/volts_per_hertz_pwm_modulator.sv -----
// Open-loop V/f three-phase modulator with min/max zero-sequence injection.
// One input transaction (a dc-link sample) yields one result transaction. The
// item runs through a sequencer: ramp, phase step, then for each of the three
// phases a sine table lookup with interpolation, a scaling multiply and, in V/f
// mode, a one-bit-per-cycle restoring divide by the dc-link sample, then
// injection and saturation. In test mode the divide and the injection are
// skipped; a low dc-link item in V/f mode skips the phases and gives zero
// duties. The next item is taken while a result waits.
module volts_per_hertz_pwm_modulator #(
  parameter int SINE_ROM_DEPTH = vfm_pkg::SINE_ROM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // vdc_sample[15:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // duty_u[15:0] duty_v[31:16] duty_w[47:32] sector_now[50:48] freq_now[76:51] zero[79:77]
  output logic [79:0] out_tdata,
  output logic        out_tuser,  // vdc_low[0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data
);
  import vfm_pkg::*;

  localparam int AW = $clog2(SINE_ROM_DEPTH);
  localparam int DW = $clog2(SINE_ROM_DEPTH + 1);
  localparam int PW = 32 + DW;
  localparam logic [AW-1:0] LAST_IDX = AW'(SINE_ROM_DEPTH - 1);
  localparam longint TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef logic signed [15:0] rom_t [SINE_ROM_DEPTH];

  // one sine table entry, built from a taylor series in fixed point
  function automatic logic signed [15:0] rom_entry(input longint k);
    logic [63:0] turn;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic        add;
    turn = (64'(k) << 32) / SINE_ROM_DEPTH;
    quad = (turn >> 30) & 64'd3;
    r    = turn & 64'h3FFF_FFFF;
    add  = 1'b0;
    if (quad[0]) r = 64'h4000_0000 - r;
    x    = (r * HALF_PI_Q30) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n < 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / TAYLOR_DIV[n];
      if (add) sum = sum + term;
      else     sum = sum - term;
      add = !add;
    end
    sum = (sum * 64'd32767 + 64'h2000_0000) >> 30;
    if (sum > 64'd32767) sum = 64'd32767;
    return (quad >= 64'd2) ? -$signed(sum[15:0]) : $signed(sum[15:0]);
  endfunction

  function automatic rom_t rom_fill();
    rom_t t;
    for (int k = 0; k < SINE_ROM_DEPTH; k++) t[k] = rom_entry(longint'(k));
    return t;
  endfunction

  localparam rom_t SINE_ROM = rom_fill();

  function automatic logic signed [15:0] sat16(input logic signed [42:0] v);
    if (v > 43'sd32767)  return 16'sh7FFF;
    if (v < -43'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // configuration registers
  logic               drive_mode_r;
  logic signed [25:0] freq_target_r;
  logic [15:0]        freq_step_r;
  logic [23:0]        phase_gain_r;
  logic [15:0]        volts_per_hz_r;
  logic [15:0]        vdc_minimum_r;
  logic [14:0]        test_duty_r;

  // state
  state_t state_r, state_nxt;
  logic signed [25:0] freq_r;
  logic [31:0]        phase_r;
  logic [2:0]         sector_r;
  logic [15:0]        vdc_r;
  logic               low_r;
  logic [1:0]         ph_r;

  // datapath registers
  logic signed [50:0] inc_r;
  logic signed [42:0] gf_r;
  logic [AW-1:0]      idx_r;
  logic [31:0]        fr_r;
  logic signed [15:0] s0_r, s1_r;
  logic signed [49:0] ip_r;
  logic signed [15:0] cos_r;
  logic signed [58:0] n_r;
  logic [DIV_STEPS-1:0] dd_r;
  logic [15:0]        rem_r;
  logic               neg_r;
  logic [5:0]         cnt_r;
  logic signed [41:0] a_r [3];
  logic signed [42:0] mid_r;

  // control
  logic in_acc, out_load;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_mode_r   <= 1'b0;
      freq_target_r  <= '0;
      freq_step_r    <= 16'd66;
      phase_gain_r   <= 24'd429497;
      volts_per_hz_r <= 16'd1255;
      vdc_minimum_r  <= 16'd640;
      test_duty_r    <= 15'd31130;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DRIVE_MODE:   drive_mode_r   <= cfg_data[0];
        REG_FREQ_TARGET:  freq_target_r  <= $signed(cfg_data);
        REG_FREQ_STEP:    freq_step_r    <= cfg_data[15:0];
        REG_PHASE_GAIN:   phase_gain_r   <= cfg_data[23:0];
        REG_VOLTS_PER_HZ: volts_per_hz_r <= cfg_data[15:0];
        REG_VDC_MINIMUM:  vdc_minimum_r  <= cfg_data[15:0];
        REG_TEST_DUTY:    test_duty_r    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_RAMP;
      S_RAMP:   state_nxt = S_GAIN;
      S_GAIN:   state_nxt = S_PHASE;
      S_PHASE:  state_nxt = (!drive_mode_r && !(vdc_r > vdc_minimum_r)) ? S_DUTY : S_ADDR;
      S_ADDR:   state_nxt = S_READ;
      S_READ:   state_nxt = S_INTERP;
      S_INTERP: state_nxt = S_COS;
      S_COS:    state_nxt = S_SCALE;
      S_SCALE:  state_nxt = S_PREP;
      S_PREP:   state_nxt = drive_mode_r ? S_STORE : S_DIV;
      S_DIV:    if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = S_STORE;
      S_STORE:  state_nxt = (ph_r == 2'd2) ? S_MID : S_ADDR;
      S_MID:    state_nxt = S_DUTY;
      S_DUTY:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == S_IDLE);
    out_load  = (state_r == S_DUTY) && (!out_tvalid || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // ramp arithmetic
  logic signed [27:0] f_up, f_dn, tgt_x;
  assign f_up  = 28'(freq_r) + $signed({12'd0, freq_step_r});
  assign f_dn  = 28'(freq_r) - $signed({12'd0, freq_step_r});
  assign tgt_x = 28'(freq_target_r);

  // table address for the current phase
  logic [31:0]   pa;
  logic [PW-1:0] prod;
  always_comb begin
    pa = phase_r + QUARTER_TURN;
    if (ph_r == 2'd1) pa = pa - THIRD_TURN;
    else if (ph_r == 2'd2) pa = pa + THIRD_TURN;
  end
  assign prod = PW'(pa) * PW'(SINE_ROM_DEPTH);

  logic [AW-1:0] nxt_idx;
  assign nxt_idx = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;

  // interpolation and scaling
  logic signed [16:0] diff;
  logic signed [49:0] ip_t;
  logic signed [42:0] op_a;
  logic [58:0]        n_abs;
  logic signed [58:0] n_t;
  assign diff  = 17'(s1_r) - 17'(s0_r);
  assign ip_t  = ip_r[49] ? ip_r + 50'sh0_FFFF_FFFF : ip_r;
  assign op_a  = drive_mode_r ? $signed({28'd0, test_duty_r}) : gf_r;
  assign n_abs = n_r[58] ? 59'(-n_r) : 59'(n_r);
  assign n_t   = n_r[58] ? n_r + 59'sd32767 : n_r;

  // serial divider step
  logic [16:0] trial;
  logic        ge;
  assign trial = {rem_r, dd_r[DIV_STEPS-1]};
  assign ge    = trial >= {1'b0, vdc_r};

  // sector and mid value
  logic [2:0]         code;
  logic [2:0]         sec_t;
  logic signed [41:0] mx, mn;
  logic signed [42:0] msum;
  always_comb begin
    code = {a_r[2] > a_r[0], a_r[1] > a_r[2], a_r[0] > a_r[1]};
    case (code)
      3'd2:    begin mx = a_r[1]; mn = a_r[2]; sec_t = 3'd2; end
      3'd3:    begin mx = a_r[0]; mn = a_r[2]; sec_t = 3'd1; end
      3'd4:    begin mx = a_r[2]; mn = a_r[0]; sec_t = 3'd4; end
      3'd5:    begin mx = a_r[2]; mn = a_r[1]; sec_t = 3'd5; end
      3'd6:    begin mx = a_r[1]; mn = a_r[0]; sec_t = 3'd3; end
      default: begin mx = a_r[0]; mn = a_r[1]; sec_t = 3'd6; end
    endcase
    msum = 43'(mx) + 43'(mn);
  end

  // sequenced datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r   <= '0;
      phase_r  <= '0;
      sector_r <= '0;
      ph_r     <= '0;
      cnt_r    <= '0;
      low_r    <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_acc) vdc_r <= in_tdata;
        S_RAMP: begin
          if (f_up < tgt_x)      freq_r <= f_up[25:0];
          else if (f_dn > tgt_x) freq_r <= f_dn[25:0];
          else                   freq_r <= freq_target_r;
        end
        S_GAIN: begin
          inc_r <= 51'(freq_r) * $signed({27'd0, phase_gain_r});
          gf_r  <= 43'(freq_r) * $signed({27'd0, volts_per_hz_r});
        end
        S_PHASE: begin
          phase_r <= phase_r + inc_r[47:16];
          low_r   <= !drive_mode_r && !(vdc_r > vdc_minimum_r);
          ph_r    <= '0;
        end
        S_ADDR: begin
          idx_r <= prod[32+AW-1:32];
          fr_r  <= prod[31:0];
        end
        S_READ: begin
          s0_r <= SINE_ROM[idx_r];
          s1_r <= SINE_ROM[nxt_idx];
        end
        S_INTERP: ip_r  <= 50'(diff) * $signed({1'b0, fr_r});
        S_COS:    cos_r <= s0_r + ip_t[47:32];
        S_SCALE:  n_r   <= 59'(op_a) * 59'(cos_r);
        S_PREP: begin
          dd_r  <= n_abs[57:17];
          rem_r <= '0;
          neg_r <= n_r[58];
          cnt_r <= '0;
        end
        S_DIV: begin
          rem_r <= ge ? 16'(trial - {1'b0, vdc_r}) : trial[15:0];
          dd_r  <= {dd_r[DIV_STEPS-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
        end
        S_STORE: begin
          if (drive_mode_r) a_r[ph_r] <= 42'($signed(n_t[30:15]));
          else a_r[ph_r] <= neg_r ? -$signed({1'b0, dd_r}) : $signed({1'b0, dd_r});
          ph_r <= ph_r + 1'b1;
        end
        S_MID: begin
          if (drive_mode_r) mid_r <= '0;
          else begin
            mid_r    <= $signed(msum + 43'(msum[42])) >>> 1;
            sector_r <= sec_t;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (out_load) begin
      out_tvalid <= 1'b1;
      out_tuser  <= low_r;
      out_tdata  <= {3'd0, freq_r, sector_r,
                     low_r ? 16'sd0 : sat16(43'(a_r[2]) - mid_r),
                     low_r ? 16'sd0 : sat16(43'(a_r[1]) - mid_r),
                     low_r ? 16'sd0 : sat16(43'(a_r[0]) - mid_r)};
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  // a low dc-link result carries zero duties
  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[47:0] == 48'd0)
    else $error("low dc-link result with nonzero duty");

  // divider never runs past its step count
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < 6'(DIV_STEPS))
    else $error("divider step count overrun");

  // an accepted transaction always starts the ramp
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_RAMP)
    else $error("accepted transaction did not start");

endmodule
